/* src/source_blocklist_packet_filter_macros.svh */
// Assertion macros for the source blocklist packet filter.
// Included by the top level; depends on nothing else.
`ifndef SOURCE_BLOCKLIST_PACKET_FILTER_MACROS_SVH
`define SOURCE_BLOCKLIST_PACKET_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is switched off while reset is high
`define SBF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbf check failed");

// Check that also holds during reset
`define SBF_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("sbf check failed");

`else

`define SBF_ASSERT(name, clk, rst, prop)
`define SBF_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

/* src/sbf_pkg.sv */
// Shared types and constants of the source blocklist packet filter.
// Used by sbf_cell and source_blocklist_packet_filter; depends on nothing.
package sbf_pkg;

   // Request kinds
   localparam logic [2:0] KIND_PACKET       = 3'd0;
   localparam logic [2:0] KIND_ADD_ADDR     = 3'd1;
   localparam logic [2:0] KIND_ADD_RANGE    = 3'd2;
   localparam logic [2:0] KIND_REMOVE_ADDR  = 3'd3;
   localparam logic [2:0] KIND_REMOVE_RANGE = 3'd4;
   localparam logic [2:0] KIND_CLEAR        = 3'd5;

   // Command status codes
   localparam logic [1:0] STATUS_PACKET    = 2'd0;
   localparam logic [1:0] STATUS_DONE      = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Ban reasons
   localparam logic [1:0] REASON_NONE = 2'd0;
   localparam logic [1:0] REASON_ADDR = 2'd1;
   localparam logic [1:0] REASON_PORT = 2'd2;

   // IP protocol numbers
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // Control register map
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFENCE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WATCHED_PORT   = 2'd1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] src_ip;
      logic [7:0]  protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        syn_flag;
      logic        ack_flag;
      logic [15:0] range_low;
      logic [15:0] range_high;
   } req_type;

   typedef struct packed {
      logic       verdict;
      logic [1:0] ban_reason;
      logic       flood_alert;
      logic       scan_alert;
      logic [1:0] cmd_status;
   } rsp_type;

   // Search token walking down the cell row
   typedef struct packed {
      logic active;     // token present at this position
      logic addr_hit;   // a live address entry equals src_ip
      logic port_hit;   // a live range holds src_port
      logic range_hit;  // a live range equals the given range exactly
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

/* src/sbf_cell.sv */
// One cell of the blocklist row: one address entry and one port range entry.
// Depends on sbf_pkg; instantiated by source_blocklist_packet_filter.
module sbf_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  sbf_pkg::req_type query,
   input  logic [CNT_W-1:0] addr_count,
   input  logic [CNT_W-1:0] range_count,
   input  sbf_pkg::tok_type prev_tok,
   input  logic [31:0]      next_addr,
   input  logic [31:0]      next_range,
   output sbf_pkg::tok_type tok_out,
   output logic [31:0]      addr_out,
   output logic [31:0]      range_out
);
   import sbf_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [31:0] addr_ff, addr_in;
   logic [31:0] range_ff, range_in;
   tok_type     tok_ff, tok_in;
   logic        addr_live, range_live;
   logic        addr_eq, range_eq, port_in_range;
   logic [31:0] range_word;

   // Entry compares against the held request
   always_comb begin
      range_word    = {query.range_high, query.range_low};
      addr_live     = MY_INDEX < addr_count;
      range_live    = MY_INDEX < range_count;
      addr_eq       = addr_live && (addr_ff == query.src_ip);
      range_eq      = range_live && (range_ff == range_word);
      port_in_range = range_live && (query.src_port >= range_ff[15:0]) &&
                      (query.src_port <= range_ff[31:16]);
   end

   // Token update and entry writes while the token sits here
   always_comb begin
      tok_in           = prev_tok;
      tok_in.addr_hit  = prev_tok.addr_hit | addr_eq;
      tok_in.port_hit  = prev_tok.port_hit | port_in_range;
      tok_in.range_hit = prev_tok.range_hit | range_eq;
      addr_in          = addr_ff;
      range_in         = range_ff;
      if (prev_tok.active) begin
         unique case (query.kind)
            KIND_ADD_ADDR: begin
               if (MY_INDEX == addr_count) addr_in = query.src_ip;
            end
            KIND_ADD_RANGE: begin
               if (MY_INDEX == range_count) range_in = range_word;
            end
            // at and after the first match, take the upper neighbor
            KIND_REMOVE_ADDR: begin
               if (tok_in.addr_hit) addr_in = next_addr;
            end
            KIND_REMOVE_RANGE: begin
               if (tok_in.range_hit) range_in = next_range;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      range_ff <= range_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_out   = tok_ff;
   assign addr_out  = addr_ff;
   assign range_out = range_ff;

endmodule

/* src/source_blocklist_packet_filter.sv */
// Source blocklist packet filter. Keeps a list of blocked source addresses and a list of
// blocked source port ranges in a row of LIST_DEPTH cells; packets are checked against
// both, commands add, remove or clear entries. One request is handled at a time: a search
// token walks the cell row one cell per cycle; when it leaves the row the result is
// registered, then copied into the response register before the next request can be taken.
// The walk spans the whole row of LIST_DEPTH cells; a previous response still waiting on
// rsp_ready holds the request in its last step for as long as it waits. Control register
// writes are taken in any cycle.
// Depends on sbf_pkg, sbf_cell and source_blocklist_packet_filter_macros.svh.
module source_blocklist_packet_filter #(
   parameter int LIST_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sbf_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sbf_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sbf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_wdata
);
   import sbf_pkg::*;

   `include "source_blocklist_packet_filter_macros.svh"

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

   state_type        state_ff, state_in;
   req_type          req_ff;
   rsp_type          res_ff, res_in, rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             start_ff;
   logic [CNT_W-1:0] addr_count_ff, addr_count_in;
   logic [CNT_W-1:0] range_count_ff, range_count_in;
   logic             defence_ff;
   logic [15:0]      watched_ff;
   logic             req_fire, tail_done, slot_free, load_rsp;
   tok_type          tail;

   tok_type     tok_chain [LIST_DEPTH+1];
   logic [31:0] addr_vals [LIST_DEPTH];
   logic [31:0] range_vals [LIST_DEPTH];

   // Cell row
   assign tok_chain[0] = '{active: start_ff, addr_hit: 1'b0, port_hit: 1'b0,
                           range_hit: 1'b0};

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [31:0] up_addr, up_range;
      if (i == LIST_DEPTH - 1) begin : g_top
         assign up_addr  = addr_vals[i];
         assign up_range = range_vals[i];
      end else begin : g_mid
         assign up_addr  = addr_vals[i+1];
         assign up_range = range_vals[i+1];
      end
      sbf_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .query       (req_ff),
         .addr_count  (addr_count_ff),
         .range_count (range_count_ff),
         .prev_tok    (tok_chain[i]),
         .next_addr   (up_addr),
         .next_range  (up_range),
         .tok_out     (tok_chain[i+1]),
         .addr_out    (addr_vals[i]),
         .range_out   (range_vals[i])
      );
   end

   assign tail      = tok_chain[LIST_DEPTH];
   assign tail_done = tail.active;

   // Result and count updates when the token leaves the row
   always_comb begin
      res_in         = '0;
      res_in.cmd_status = STATUS_DONE;
      addr_count_in  = addr_count_ff;
      range_count_in = range_count_ff;
      unique case (req_ff.kind)
         KIND_PACKET: begin
            res_in.cmd_status = STATUS_PACKET;
            if (tail.addr_hit) begin
               res_in.verdict    = 1'b1;
               res_in.ban_reason = REASON_ADDR;
            end else if ((req_ff.protocol == PROTO_TCP || req_ff.protocol == PROTO_UDP) &&
                         tail.port_hit) begin
               res_in.verdict    = 1'b1;
               res_in.ban_reason = REASON_PORT;
            end else if (req_ff.protocol == PROTO_TCP && defence_ff) begin
               res_in.flood_alert = req_ff.dst_port == watched_ff;
               res_in.scan_alert  = req_ff.syn_flag & ~req_ff.ack_flag;
            end
         end
         KIND_ADD_ADDR: begin
            if (addr_count_ff == FULL_COUNT) res_in.cmd_status = STATUS_FULL;
            else addr_count_in = addr_count_ff + CNT_W'(1);
         end
         KIND_ADD_RANGE: begin
            if (range_count_ff == FULL_COUNT) res_in.cmd_status = STATUS_FULL;
            else range_count_in = range_count_ff + CNT_W'(1);
         end
         KIND_REMOVE_ADDR: begin
            if (tail.addr_hit) addr_count_in = addr_count_ff - CNT_W'(1);
            else res_in.cmd_status = STATUS_NOT_FOUND;
         end
         KIND_REMOVE_RANGE: begin
            if (tail.range_hit) range_count_in = range_count_ff - CNT_W'(1);
            else res_in.cmd_status = STATUS_NOT_FOUND;
         end
         KIND_CLEAR: begin
            addr_count_in  = '0;
            range_count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Sequencer: next state and handshakes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      slot_free = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (tail_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      req_fire     = req_valid && req_ready;
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_data;
      if (state_ff == ST_SWEEP && tail_done) res_ff <= res_in;
      if (load_rsp) rsp_ff <= res_ff;
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         addr_count_ff  <= '0;
         range_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= req_fire;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_SWEEP && tail_done) begin
            addr_count_ff  <= addr_count_in;
            range_count_ff <= range_count_in;
         end
      end
   end

   // Control registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         defence_ff <= 1'b0;
         watched_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEFENCE_ENABLE) defence_ff <= csr_wdata[0];
         if (csr_index == CSR_WATCHED_PORT) watched_ff <= csr_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `SBF_ASSERT(a_count_bound, clock, reset,
      (addr_count_ff <= FULL_COUNT) && (range_count_ff <= FULL_COUNT))
   `SBF_ASSERT(a_accept_starts_sweep, clock, reset,
      req_fire |=> (state_ff == ST_SWEEP) && start_ff)
   `SBF_ASSERT(a_tail_only_in_sweep, clock, reset,
      tail_done |-> (state_ff == ST_SWEEP))
   `SBF_ASSERT(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))

endmodule
